// ===== src/css_pkg.sv =====
// ----------------------------------------------------------------------------
// css_pkg: shared types and constants for the comment span scanner
// Holds character codes, input op codes, comment state codes, the result
// word layout and the saturating offset increment.
// ----------------------------------------------------------------------------
package css_pkg;

    localparam int OFFS_W = 16;
    localparam int CH_W   = 16;

    // offsets saturate here
    localparam logic [OFFS_W-1:0] OFFSET_MAX = 16'hFFFF;

    localparam logic [CH_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CH_W-1:0] CH_APOS      = 16'h0027;
    localparam logic [CH_W-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [CH_W-1:0] CH_SLASH     = 16'h002F;
    localparam logic [CH_W-1:0] CH_STAR      = 16'h002A;
    localparam logic [CH_W-1:0] CH_NEWLINE   = 16'h000A;

    typedef enum logic [1:0] {
        OP_LINE_START = 2'd0,
        OP_CHAR       = 2'd1,
        OP_LINE_END   = 2'd2
    } css_op_t;

    typedef enum logic [1:0] {
        CK_NONE  = 2'd0,
        CK_LINE  = 2'd1,
        CK_BLOCK = 2'd2
    } css_ck_t;

    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [OFFS_W-1:0] span_start;
        logic [OFFS_W-1:0] span_end;
        logic              pure_comment;
        logic              comment_or_white;
        logic              last;
    } css_res_t;

    // up to two results leave the scanner for one word
    typedef struct packed {
        logic [1:0] count;
        css_res_t   res0;
        css_res_t   res1;
    } css_push_t;

    function automatic logic [OFFS_W-1:0] sat_inc(input logic [OFFS_W-1:0] v);
        logic [OFFS_W-1:0] r;
        if (v >= OFFSET_MAX) begin
            r = OFFSET_MAX;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/css_scan.sv =====
// ----------------------------------------------------------------------------
// css_scan: input register, scan state and per-word scan logic
// Registers the incoming word, then updates string, escape and comment
// state in one pass and hands up to two results to the result stage.
// ----------------------------------------------------------------------------
module css_scan (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               in_op,
    input  logic [css_pkg::CH_W-1:0]   in_ch,
    input  logic [css_pkg::OFFS_W-1:0] in_lead_offset,
    input  logic                     in_starts_line_comment,
    input  logic                     in_starts_block_comment,
    input  logic                     in_ends_block_close,
    input  logic                     in_has_trailing_space,
    input  logic                     res_room,
    output logic                     res_load,
    output css_pkg::css_push_t       res_push
);
    import css_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [1:0]        op_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [OFFS_W-1:0] lead_reg;
    logic              sl_reg, sb_reg, ec_reg, ts_reg;

    // scan state
    logic              in_string_reg, in_string_next;
    logic              escaped_reg, escaped_next;
    logic [CH_W-1:0]   quote_reg, quote_next;
    logic [CH_W-1:0]   prev_reg, prev_next;
    css_ck_t           ck_reg, ck_next;
    logic              first_reg, first_next;
    logic              pure_reg, pure_next;
    logic              white_reg, white_next;
    logic [OFFS_W-1:0] position_reg, position_next;
    logic [OFFS_W-1:0] open_start_reg, open_start_next;
    logic [OFFS_W-1:0] open_end_reg, open_end_next;
    logic [2:0]        line_flags_reg, line_flags_next;

    logic              do_scan;
    logic              span;
    logic [CH_W-1:0]   c;
    logic              advance;
    css_push_t         push;

    always_comb begin
        in_string_next  = in_string_reg;
        escaped_next    = escaped_reg;
        quote_next      = quote_reg;
        prev_next       = prev_reg;
        ck_next         = ck_reg;
        first_next      = first_reg;
        pure_next       = pure_reg;
        white_next      = white_reg;
        position_next   = position_reg;
        open_start_next = open_start_reg;
        open_end_next   = open_end_reg;
        line_flags_next = line_flags_reg;
        do_scan         = 1'b0;
        span            = 1'b0;
        c               = CH_NEWLINE;
        push            = '0;

        unique case (css_op_t'(op_reg))
            OP_LINE_START: begin
                position_next   = (lead_reg > OFFSET_MAX) ? OFFSET_MAX : lead_reg;
                open_start_next = '0;
                open_end_next   = '0;
                line_flags_next = {ec_reg, sb_reg, sl_reg};
            end
            OP_CHAR: begin
                do_scan = 1'b1;
                c       = ch_reg;
            end
            OP_LINE_END: begin
                do_scan = 1'b1;
                if (ts_reg && ck_reg == CK_NONE) begin
                    pure_next = 1'b0;
                end
            end
            default: ;
        endcase

        if (do_scan) begin
            if (escaped_reg) begin
                // character after a backslash in a string is swallowed
                escaped_next  = 1'b0;
                prev_next     = '0;
                position_next = sat_inc(position_reg);
            end else begin
                unique case (c)
                    CH_BACKSLASH: begin
                        if (in_string_reg) begin
                            escaped_next = 1'b1;
                        end
                    end
                    CH_APOS, CH_QUOTE: begin
                        if (ck_reg == CK_NONE) begin
                            if (!in_string_reg) begin
                                in_string_next = 1'b1;
                                quote_next     = c;
                            end else if (quote_reg == c) begin
                                in_string_next = 1'b0;
                            end
                        end
                    end
                    CH_SLASH: begin
                        if (!in_string_reg) begin
                            if (ck_reg == CK_NONE && prev_reg == CH_SLASH) begin
                                ck_next         = CK_LINE;
                                pure_next       = line_flags_reg[0];
                                white_next      = line_flags_reg[0];
                                open_start_next = (position_reg == '0) ? '0
                                                : position_reg - 1'b1;
                                if (position_reg != OFFS_W'(1)) begin
                                    pure_next = 1'b0;
                                end
                            end else if (prev_reg == CH_STAR && ck_reg == CK_BLOCK) begin
                                ck_next       = CK_NONE;
                                open_end_next = sat_inc(position_reg);
                                span          = 1'b1;
                                if (!first_reg && line_flags_reg[2]) begin
                                    pure_next  = 1'b1;
                                    white_next = 1'b1;
                                end else if (!first_reg) begin
                                    pure_next = white_next;
                                end
                            end
                        end
                    end
                    CH_STAR: begin
                        if (!in_string_reg && prev_reg == CH_SLASH && ck_reg == CK_NONE) begin
                            ck_next = CK_BLOCK;
                            if (line_flags_reg[1]) begin
                                white_next = 1'b1;
                            end
                            pure_next       = white_next;
                            first_next      = 1'b1;
                            open_start_next = (position_reg == '0) ? '0
                                            : position_reg - 1'b1;
                            if (position_reg != OFFS_W'(1)) begin
                                pure_next = 1'b0;
                            end
                        end
                    end
                    CH_NEWLINE: begin
                        if (ck_reg == CK_LINE) begin
                            ck_next       = CK_NONE;
                            open_end_next = position_reg;
                            span          = 1'b1;
                        end
                        if (ck_next == CK_BLOCK && !first_reg) begin
                            pure_next  = 1'b1;
                            white_next = 1'b1;
                        end
                        // comment opened on this line but not yet closed ends its span here
                        if (!span && open_start_reg != '0 && open_end_reg == '0) begin
                            open_end_next = position_reg;
                            span          = 1'b1;
                        end
                        first_next = 1'b0;
                    end
                    default: begin
                        if (ck_reg == CK_NONE) begin
                            pure_next  = 1'b0;
                            white_next = 1'b0;
                        end
                    end
                endcase
                prev_next     = c;
                position_next = sat_inc(position_reg);
            end
        end

        if (do_scan) begin
            if (span) begin
                push.res0.kind       = KIND_SPAN;
                push.res0.span_start = open_start_next;
                push.res0.span_end   = open_end_next;
            end
            if (css_op_t'(op_reg) == OP_LINE_END) begin
                if (span) begin
                    push.count                 = 2'd2;
                    push.res1.kind             = KIND_STATUS;
                    push.res1.pure_comment     = pure_next;
                    push.res1.comment_or_white = white_next;
                    push.res1.last             = 1'b1;
                end else begin
                    push.count                 = 2'd1;
                    push.res0.kind             = KIND_STATUS;
                    push.res0.pure_comment     = pure_next;
                    push.res0.comment_or_white = white_next;
                    push.res0.last             = 1'b1;
                end
            end else if (span) begin
                push.count     = 2'd1;
                push.res0.last = 1'b1;
            end
        end
    end

    assign advance  = in_valid_reg && (push.count == 2'd0 || res_room);
    assign in_ready = !in_valid_reg || advance;
    assign res_load = advance && push.count != 2'd0;
    assign res_push = push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_string_reg  <= 1'b0;
            escaped_reg    <= 1'b0;
            quote_reg      <= '0;
            prev_reg       <= '0;
            ck_reg         <= CK_NONE;
            first_reg      <= 1'b0;
            pure_reg       <= 1'b0;
            white_reg      <= 1'b0;
            position_reg   <= '0;
            open_start_reg <= '0;
            open_end_reg   <= '0;
            line_flags_reg <= '0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                in_string_reg  <= in_string_next;
                escaped_reg    <= escaped_next;
                quote_reg      <= quote_next;
                prev_reg       <= prev_next;
                ck_reg         <= ck_next;
                first_reg      <= first_next;
                pure_reg       <= pure_next;
                white_reg      <= white_next;
                position_reg   <= position_next;
                open_start_reg <= open_start_next;
                open_end_reg   <= open_end_next;
                line_flags_reg <= line_flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            op_reg   <= in_op;
            ch_reg   <= in_ch;
            lead_reg <= in_lead_offset;
            sl_reg   <= in_starts_line_comment;
            sb_reg   <= in_starts_block_comment;
            ec_reg   <= in_ends_block_close;
            ts_reg   <= in_has_trailing_space;
        end
    end

endmodule

// ===== src/css_out_stage.sv =====
// ----------------------------------------------------------------------------
// css_out_stage: two-slot result register
// Takes a group of one or two results and presents them one per cycle while
// out_ready is high, slot 1 moving down into slot 0 as slot 0 is taken.
// ----------------------------------------------------------------------------
module css_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   res_load,
    input  css_pkg::css_push_t     res_push,
    output logic                   res_room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output css_pkg::css_res_t      out_res
);
    import css_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    css_res_t   slot0_reg, slot0_next;
    css_res_t   slot1_reg, slot1_next;
    logic       pop;

    assign pop      = cnt_reg != 2'd0 && out_ready;
    assign res_room = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop);

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        priority if (res_load) begin
            cnt_next   = res_push.count;
            slot0_next = res_push.res0;
            slot1_next = res_push.res1;
        end else if (pop) begin
            cnt_next   = cnt_reg - 1'b1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid = cnt_reg != 2'd0;
    assign out_res   = slot0_reg;

endmodule

// ===== src/comment_span_scanner.sv =====
// ----------------------------------------------------------------------------
// comment_span_scanner: C-style comment finder for a text stream
// Words carry line starts, characters and line ends; results are comment
// spans and end-of-line status.
// ----------------------------------------------------------------------------
// One word is taken per cycle unless a word that yields results waits for
// room in the result register. A word passes the input register, then the
// result register. A word yields zero, one or two results, handed out one
// per cycle while m_tready is high; a line end that also closes a span holds
// the next word with results while both drain. Offsets saturate at 65535.
module comment_span_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] ch, [31:16] lead_offset, [32] starts_line_comment,
    // [33] starts_block_comment, [34] ends_block_close, [35] has_trailing_space
    input  logic [39:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] span_start, [31:16] span_end, [32] pure_comment, [33] comment_or_white
    output logic [39:0] m_tdata,
    // [0] kind
    output logic        m_tuser,
    output logic        m_tlast
);
    import css_pkg::*;

    logic      res_room;
    logic      res_load;
    css_push_t res_push;
    css_res_t  out_res;

    css_scan u_scan (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .in_valid                (s_tvalid),
        .in_ready                (s_tready),
        .in_op                   (s_tuser),
        .in_ch                   (s_tdata[15:0]),
        .in_lead_offset          (s_tdata[31:16]),
        .in_starts_line_comment  (s_tdata[32]),
        .in_starts_block_comment (s_tdata[33]),
        .in_ends_block_close     (s_tdata[34]),
        .in_has_trailing_space   (s_tdata[35]),
        .res_room                (res_room),
        .res_load                (res_load),
        .res_push                (res_push)
    );

    css_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res_push  (res_push),
        .res_room  (res_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b0, out_res.comment_or_white, out_res.pure_comment,
                      out_res.span_end, out_res.span_start};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== src/css_checker.sv =====
// ----------------------------------------------------------------------------
// css_checker: port-level checks for the comment span scanner
// Watches the result channel for layout and ordering rules of the results.
// ----------------------------------------------------------------------------
module css_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import css_pkg::*;

    // a stalled word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word dropped while stalled");

    // status words carry no span, span words carry no flags
    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tdata[31:0] == 32'd0 && m_tlast)
        else $error("status word with span bits or without last");

    a_span_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SPAN |-> m_tdata[39:32] == 8'd0)
        else $error("span word with flag bits set");

    // a span without last is always followed by its status word
    a_span_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_SPAN && !m_tlast
        |=> m_tvalid && m_tuser == KIND_STATUS)
        else $error("span not followed by line status");

endmodule

bind comment_span_scanner css_checker u_css_checker (.*);

// ===== verif/tb_comment_span_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_comment_span_scanner: self-checking bench for the comment span scanner
// Drives line-start, character and line-end words and predicts every comment
// span and end-of-line status in a scan model kept in the bench. Directed
// lines cover comments, strings, escapes and offset corner cases; random
// lines follow under changing idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb_comment_span_scanner;
    import css_pkg::*;

    // op code the scanner ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // per-word flag nibble, bit 0 up: line comment start, block start,
    // block close at end, trailing space
    localparam logic [3:0] FL_NONE = 4'b0000;
    localparam logic [3:0] FL_SLC  = 4'b0001;
    localparam logic [3:0] FL_SBC  = 4'b0010;
    localparam logic [3:0] FL_EBC  = 4'b0100;
    localparam logic [3:0] FL_HTS  = 4'b1000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] ch, [31:16] lead_offset, [32] starts_line_comment,
    // [33] starts_block_comment, [34] ends_block_close, [35] has_trailing_space
    logic [39:0] s_tdata  = '0;
    // [1:0] op
    logic [1:0]  s_tuser  = OP_LINE_START;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] span_start, [31:16] span_end, [32] pure_comment, [33] comment_or_white
    logic [39:0] m_tdata;
    // [0] kind
    logic        m_tuser;
    logic        m_tlast;

    comment_span_scanner DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    int send_idle_pct = 16;
    int recv_idle_pct = 51;
    int mismatches    = 0;

    css_res_t span_status_q[$];

    // queue one expected result word
    function automatic void expect_word(input css_res_t r);
        span_status_q = {span_status_q, r};
    endfunction

    // scan state of the bench model
    logic              st_in_str = 1'b0;
    logic              st_esc    = 1'b0;
    logic [CH_W-1:0]   st_quote  = '0;
    logic [CH_W-1:0]   st_prev   = '0;
    css_ck_t           st_ck     = CK_NONE;
    logic              st_first  = 1'b0;
    logic              st_pure   = 1'b0;
    logic              st_white  = 1'b0;
    logic [OFFS_W-1:0] st_pos    = '0;
    logic [OFFS_W-1:0] st_open_s = '0;
    logic [OFFS_W-1:0] st_open_e = '0;
    logic [2:0]        st_lflags = '0;

    function automatic logic [OFFS_W-1:0] next_offset(input logic [OFFS_W-1:0] v);
        return (v == OFFSET_MAX) ? OFFSET_MAX : v + 1'b1;
    endfunction

    // opener's first character sits one before the current position
    function automatic void open_comment();
        st_open_s = (st_pos == '0) ? '0 : st_pos - 1'b1;
        if (st_pos != 16'd1) begin
            st_pure = 1'b0;
        end
    endfunction

    function automatic logic scan_unit(input logic [CH_W-1:0] c);
        logic span;
        span = 1'b0;
        if (st_esc) begin
            st_esc  = 1'b0;
            st_prev = '0;
            st_pos  = next_offset(st_pos);
            return 1'b0;
        end
        if (c == CH_BACKSLASH) begin
            if (st_in_str) begin
                st_esc = 1'b1;
            end
        end else if (c == CH_APOS || c == CH_QUOTE) begin
            if (st_ck == CK_NONE) begin
                if (!st_in_str) begin
                    st_in_str = 1'b1;
                    st_quote  = c;
                end else if (st_quote == c) begin
                    st_in_str = 1'b0;
                end
            end
        end else if (c == CH_SLASH) begin
            if (!st_in_str) begin
                if (st_ck == CK_NONE && st_prev == CH_SLASH) begin
                    st_ck    = CK_LINE;
                    st_pure  = st_lflags[0];
                    st_white = st_lflags[0];
                    open_comment();
                end else if (st_prev == CH_STAR && st_ck == CK_BLOCK) begin
                    st_ck     = CK_NONE;
                    st_open_e = next_offset(st_pos);
                    span      = 1'b1;
                    if (!st_first && st_lflags[2]) begin
                        st_pure  = 1'b1;
                        st_white = 1'b1;
                    end else if (!st_first) begin
                        st_pure = st_white;
                    end
                end
            end
        end else if (c == CH_STAR) begin
            if (!st_in_str && st_prev == CH_SLASH && st_ck == CK_NONE) begin
                st_ck = CK_BLOCK;
                if (st_lflags[1]) begin
                    st_white = 1'b1;
                end
                st_pure  = st_white;
                st_first = 1'b1;
                open_comment();
            end
        end else if (c == CH_NEWLINE) begin
            if (st_ck == CK_LINE) begin
                st_ck     = CK_NONE;
                st_open_e = st_pos;
                span      = 1'b1;
            end
            if (st_ck == CK_BLOCK && !st_first) begin
                st_pure  = 1'b1;
                st_white = 1'b1;
            end
            // a comment opened on this line but not yet closed
            if (!span && st_open_s != '0 && st_open_e == '0) begin
                st_open_e = st_pos;
                span      = 1'b1;
            end
            st_first = 1'b0;
        end else begin
            if (st_ck == CK_NONE) begin
                st_pure  = 1'b0;
                st_white = 1'b0;
            end
        end
        st_prev = c;
        st_pos  = next_offset(st_pos);
        return span;
    endfunction

    task automatic scan_predict(input logic [1:0] op, input logic [CH_W-1:0] ch,
                                input logic [OFFS_W-1:0] lead, input logic [3:0] flags);
        logic span;
        case (op)
            OP_LINE_START: begin
                st_pos    = lead;
                st_open_s = '0;
                st_open_e = '0;
                st_lflags = flags[2:0];
            end
            OP_CHAR: begin
                if (scan_unit(ch)) begin
                    expect_word('{KIND_SPAN, st_open_s, st_open_e, 1'b0, 1'b0, 1'b1});
                end
            end
            OP_LINE_END: begin
                if (flags[3] && st_ck == CK_NONE) begin
                    st_pure = 1'b0;
                end
                span = scan_unit(CH_NEWLINE);
                if (span) begin
                    expect_word('{KIND_SPAN, st_open_s, st_open_e, 1'b0, 1'b0, 1'b0});
                end
                expect_word('{KIND_STATUS, '0, '0, st_pure, st_white, 1'b1});
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_word(input logic [1:0] op, input logic [CH_W-1:0] ch,
                             input logic [OFFS_W-1:0] lead, input logic [3:0] flags);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, flags, lead, ch};
        do @(posedge aclk); while (!s_tready);
        scan_predict(op, ch, lead, flags);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_word(OP_CHAR, {8'h00, txt[i]}, '0, FL_NONE);
        end
    endtask

    function automatic logic [CH_W-1:0] pick_char();
        logic [CH_W-1:0] c;
        case ($urandom_range(0, 15))
            0, 1, 2: c = CH_SLASH;
            3, 4:    c = CH_STAR;
            5:       c = CH_QUOTE;
            6:       c = CH_APOS;
            7:       c = CH_BACKSLASH;
            8:       c = CH_NEWLINE;
            9:       c = 16'h0020;
            10, 11:  c = 16'($urandom_range(16'h61, 16'h7A));
            default: c = 16'($urandom);
        endcase
        return c;
    endfunction

    // ---- result checking ----

    always @(posedge aclk) begin : result_check
        css_res_t got;
        css_res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[32], m_tdata[33],
                        m_tlast};
                if (span_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"unexpected word: kind=%0d start=%0d end=%0d",
                                  " pure=%0d cow=%0d last=%0d"},
                                 got.kind, got.span_start, got.span_end, got.pure_comment,
                                 got.comment_or_white, got.last);
                    end
                end else begin
                    want = span_status_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"mismatch: expected kind=%0d start=%0d end=%0d",
                                      " pure=%0d cow=%0d last=%0d"},
                                     want.kind, want.span_start, want.span_end,
                                     want.pure_comment, want.comment_or_white, want.last);
                            $display({"          actual   kind=%0d start=%0d end=%0d",
                                      " pure=%0d cow=%0d last=%0d"},
                                     got.kind, got.span_start, got.span_end, got.pure_comment,
                                     got.comment_or_white, got.last);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---- tests ----

    task automatic test_line_comment();
        send_word(OP_LINE_START, 16'hFFFF, 16'd4, FL_SLC);
        send_text("//x");
        send_word(OP_LINE_END, '0, '0, FL_HTS);
    endtask

    // block comment spanning two lines, closed at the saturated offset
    task automatic test_block_and_saturation();
        send_word(OP_LINE_START, '0, '0, FL_SBC);
        send_word(OP_CHAR, 16'hFFFF, '0, FL_NONE);
        send_word(OP_CHAR, 16'h0000, '0, FL_NONE);
        send_text("/*");
        send_word(OP_LINE_END, '0, '0, FL_NONE);
        send_word(OP_LINE_START, '0, OFFSET_MAX, FL_EBC);
        send_text("*/");
        send_word(OP_LINE_END, '0, '0, FL_HTS);
    endtask

    // strings of both quote kinds, an escape, and an escaped line end
    task automatic test_strings_and_escapes();
        send_word(OP_LINE_START, '0, 16'd2, FL_NONE);
        send_word(OP_CHAR, CH_QUOTE, '0, FL_NONE);
        send_word(OP_CHAR, CH_BACKSLASH, '0, FL_NONE);
        send_word(OP_CHAR, CH_QUOTE, '0, FL_NONE);
        send_word(OP_CHAR, CH_QUOTE, '0, FL_NONE);
        send_word(OP_CHAR, CH_APOS, '0, FL_NONE);
        send_word(OP_CHAR, CH_BACKSLASH, '0, FL_NONE);
        send_word(OP_LINE_END, '0, '0, FL_NONE);
    endtask

    // slash at the end of one line and slash at offset zero of the next,
    // then a newline as a character word and an ignored op
    task automatic test_opener_at_zero();
        send_word(OP_LINE_START, '0, '0, FL_NONE);
        send_word(OP_CHAR, CH_APOS, '0, FL_NONE);
        send_word(OP_CHAR, CH_SLASH, '0, FL_NONE);
        send_word(OP_LINE_START, '0, '0, FL_SLC);
        send_word(OP_CHAR, CH_SLASH, '0, FL_NONE);
        send_word(OP_CHAR, CH_NEWLINE, '0, FL_NONE);
        send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF);
        send_word(OP_LINE_END, '0, '0, FL_NONE);
    endtask

    task automatic test_random_lines(input int n_words);
        int                sent;
        int                n_chars;
        logic [1:0]        op;
        logic [OFFS_W-1:0] lead;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray word with any op and payload
                op = 2'($urandom);
                send_word(op, 16'($urandom), 16'($urandom), 4'($urandom));
                if (op != OP_UNUSED) begin
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 9))
                    0:       lead = 16'($urandom);
                    1:       lead = OFFSET_MAX - 16'($urandom_range(0, 20));
                    default: lead = 16'($urandom_range(0, 40));
                endcase
                send_word(OP_LINE_START, 16'($urandom), lead, 4'($urandom));
                n_chars = $urandom_range(0, 12);
                repeat (n_chars) begin
                    send_word(OP_CHAR, pick_char(), 16'($urandom), 4'($urandom));
                end
                sent += 1 + n_chars;
                // sometimes the line end is missing and the next line runs on
                if ($urandom_range(0, 9) != 0) begin
                    send_word(OP_LINE_END, 16'($urandom), 16'($urandom), 4'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin : run_tests
        int drain_cycles;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_line_comment();
        test_block_and_saturation();
        test_strings_and_escapes();
        test_opener_at_zero();

        test_random_lines(160);
        send_idle_pct = 51;
        recv_idle_pct = 16;
        test_random_lines(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(160);

        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (span_status_q.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);

        if (span_status_q.size() != 0) begin
            $display("%0d expected words never arrived", span_status_q.size());
        end
        if (mismatches == 0 && span_status_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== comment_span_scanner.f =====
src/css_pkg.sv
src/css_scan.sv
src/css_out_stage.sv
src/comment_span_scanner.sv
src/css_checker.sv
verif/tb_comment_span_scanner.sv
